[src/assert_macros.svh]
// Assertion helpers used by the checker file fss_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fss_pkg.sv]
package fss_pkg;

  localparam int MAX_QUERY  = 16;
  localparam int QLEN_W     = $clog2(MAX_QUERY + 1);
  localparam int QIDX_W     = $clog2(MAX_QUERY);
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 8;
  localparam int GAP_W      = 8;
  localparam int BONUS_W    = 5;
  localparam int SCORE_W    = 13;
  localparam int OUT_SCORE_W = 12;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [QLEN_W-1:0]         MAX_QUERY_LEN     = QLEN_W'(MAX_QUERY);
  localparam logic [LEN_W-1:0]          MAX_STRING_LENGTH = 8'd255;
  localparam logic [GAP_W-1:0]          GAP_LIMIT         = 8'd255;
  localparam logic [CHAR_W-1:0]         SPACE_CHAR        = 8'h20;
  localparam logic signed [SCORE_W-1:0] WORD_START_BONUS  = 13'sd10;
  localparam logic signed [SCORE_W-1:0] CATEGORY_PENALTY  = 13'sd50;
  localparam logic signed [SCORE_W-1:0] SCORE_LIMIT       = 13'sd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LOW  = 2'd0,
    CFG_QUERY_HIGH = 2'd1,
    CFG_QUERY_LEN  = 2'd2
  } cfg_index_t;

  // Running match state of the string currently streaming in
  typedef struct packed {
    logic [QLEN_W-1:0]         query_position;
    logic [GAP_W-1:0]          gap_count;
    logic [BONUS_W-1:0]        run_bonus;
    logic                      previous_matched;
    logic                      word_start_next;
    logic signed [SCORE_W-1:0] running_score;
    logic [LEN_W-1:0]          string_length;
  } str_state_t;

  localparam str_state_t STR_RESET = '{
    query_position:   '0,
    gap_count:        '0,
    run_bonus:        '0,
    previous_matched: 1'b0,
    word_start_next:  1'b1,
    running_score:    '0,
    string_length:    '0
  };

  // Result of one finished string
  typedef struct packed {
    logic                      matched;
    logic signed [SCORE_W-1:0] score;
  } str_result_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

[src/fuzzy_subsequence_scorer_top.sv]
// Fuzzy subsequence scorer: streams the characters of a command entry, the
// name first and then the category, each string closed by an item with
// s_tlast high, and tests both against the query held in the configuration
// registers (case-insensitive, greedy from the left). After the item that
// closes the category one result item leaves on the m_ side carrying the
// match flag, the better of the name score and the category score plus 50,
// and whether the name won. Throughput is one item per cycle unless a category
// end waits on a stalled output: an accepted item sits in the input register
// while the per-character compare/add logic updates the string state, and a
// category end then lands in the output register. Only a stalled output
// register holds back the input, and then only when the waiting item closes
// a category. Configuration writes take effect on the next edge; the user must
// make them only while the block is idle; the block does not enforce this.
module fuzzy_subsequence_scorer_top (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] character, [8] no_character, [15:9] zero
  input  logic        s_tlast,   // last item of the current string
  input  logic        s_tuser,   // kind: 0 name, 1 category
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] entry_matched, [12:1] combined_score,
                                 // [13] name_was_best, [15:14] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import fss_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]  query_low;
  logic [CFG_W-1:0]  query_high;
  logic [QLEN_W-1:0] query_length;
  logic [QLEN_W-1:0] qlen;

  // input register
  logic              in_valid;
  logic              in_kind;
  logic [CHAR_W-1:0] in_char;
  logic              in_none;
  logic              in_last;

  // string and entry state
  str_state_t  str_state;
  str_state_t  str_state_next;
  str_result_t str_res;
  str_result_t name_res;

  // output register
  logic                   out_matched;
  logic [OUT_SCORE_W-1:0] out_score;
  logic                   out_name_best;
  logic                   comb_matched;
  logic [OUT_SCORE_W-1:0] comb_score;
  logic                   comb_name_best;

  logic out_free;
  logic emits;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_low    <= '0;
      query_high   <= '0;
      query_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_QUERY_LOW:  query_low    <= cfg_data;
        CFG_QUERY_HIGH: query_high   <= cfg_data;
        CFG_QUERY_LEN:  query_length <= cfg_data[QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // lengths beyond the query store clamp to its size
  assign qlen = (query_length > MAX_QUERY_LEN) ? MAX_QUERY_LEN : query_length;

  // Only a category end needs room in the output register.
  assign out_free = !m_tvalid || m_tready;
  assign emits    = in_last && in_kind;
  assign advance  = in_valid && (!emits || out_free);
  assign s_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_char <= s_tdata[CHAR_W-1:0];
      in_none <= s_tdata[CHAR_W];
      in_last <= s_tlast;
    end
  end

  fss_char_match u_match (
    .state        (str_state),
    .character    (in_char),
    .no_character (in_none),
    .query_chars  ({query_high, query_low}),
    .qlen         (qlen),
    .state_next   (str_state_next),
    .result       (str_res)
  );

  fss_combine u_combine (
    .name_res       (name_res),
    .cat_res        (str_res),
    .entry_matched  (comb_matched),
    .combined_score (comb_score),
    .name_was_best  (comb_name_best)
  );

  // A string end clears the running state; a name end parks its result
  // until the category closes, which consumes and clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      str_state <= STR_RESET;
      name_res  <= '0;
    end else if (advance) begin
      if (in_last) begin
        str_state <= STR_RESET;
        if (in_kind) begin
          name_res <= '0;
        end else begin
          name_res <= str_res;
        end
      end else begin
        str_state <= str_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emits) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emits) begin
      out_matched   <= comb_matched;
      out_score     <= comb_score;
      out_name_best <= comb_name_best;
    end
  end

  assign m_tdata = {2'b00, out_name_best, out_score, out_matched};

endmodule

[src/fss_char_match.sv]
module fss_char_match (
  input  fss_pkg::str_state_t        state,
  input  logic [7:0]                 character,
  input  logic                       no_character,
  input  logic [127:0]               query_chars,
  input  logic [4:0]                 qlen,
  output fss_pkg::str_state_t        state_next,
  output fss_pkg::str_result_t       result
);
  import fss_pkg::*;

  logic [CHAR_W-1:0]         query_char;
  logic [GAP_W+2:0]          gap_cost;
  logic signed [SCORE_W-1:0] end_score;

  assign query_char = fold_case(
    query_chars[state.query_position[QIDX_W-1:0]*CHAR_W +: CHAR_W]);

  always_comb begin
    state_next = state;
    if (!no_character) begin
      if (state.query_position < qlen) begin
        if (fold_case(character) == query_char) begin
          if (state.word_start_next) begin
            state_next.running_score = state_next.running_score - WORD_START_BONUS;
          end
          if (state.previous_matched) begin
            state_next.run_bonus     = state.run_bonus + BONUS_W'(1);
            state_next.running_score = state_next.running_score
                                     - signed'(SCORE_W'(state_next.run_bonus));
          end else begin
            state_next.run_bonus = '0;
          end
          state_next.previous_matched = 1'b1;
          state_next.query_position   = state.query_position + QLEN_W'(1);
        end else begin
          if (state.query_position != '0 && state.gap_count < GAP_LIMIT) begin
            state_next.gap_count = state.gap_count + GAP_W'(1);
          end
          state_next.previous_matched = 1'b0;
        end
      end
      state_next.word_start_next = (character == SPACE_CHAR);
      if (state.string_length < MAX_STRING_LENGTH) begin
        state_next.string_length = state.string_length + LEN_W'(1);
      end
    end
  end

  // 5 * gaps as shift-and-add
  assign gap_cost  = {1'b0, state_next.gap_count, 2'b00}
                   + (GAP_W+3)'(state_next.gap_count);
  assign end_score = state_next.running_score
                   + signed'(SCORE_W'(gap_cost))
                   + signed'(SCORE_W'(state_next.string_length));

  always_comb begin
    if (qlen == '0) begin
      result.matched = 1'b1;
      result.score   = '0;
    end else if (state_next.query_position >= qlen) begin
      result.matched = 1'b1;
      result.score   = end_score;
    end else begin
      result.matched = 1'b0;
      result.score   = '0;
    end
  end

endmodule

[src/fss_combine.sv]
module fss_combine (
  input  fss_pkg::str_result_t name_res,
  input  fss_pkg::str_result_t cat_res,
  output logic                 entry_matched,
  output logic [11:0]          combined_score,
  output logic                 name_was_best
);
  import fss_pkg::*;

  logic signed [SCORE_W-1:0] cat_score;
  logic signed [SCORE_W-1:0] best;

  assign cat_score = cat_res.score + CATEGORY_PENALTY;

  always_comb begin
    name_was_best = 1'b0;
    best          = '0;
    priority if (name_res.matched && cat_res.matched) begin
      name_was_best = (name_res.score <= cat_score);
      best          = name_was_best ? name_res.score : cat_score;
    end else if (name_res.matched) begin
      name_was_best = 1'b1;
      best          = name_res.score;
    end else if (cat_res.matched) begin
      best = cat_score;
    end else begin
      // neither string matched
      best = '0;
    end
    if (best > SCORE_LIMIT) begin
      best = SCORE_LIMIT;
    end
  end

  assign entry_matched  = name_res.matched || cat_res.matched;
  assign combined_score = best[OUT_SCORE_W-1:0];

endmodule

[src/fss_checker.sv]
`include "assert_macros.svh"

module fss_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a result that waits must not vanish or change
  `ASSERT_CLK(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")

  // nothing leaves straight after reset
  `ASSERT_CLK_RST(a_reset_empty, rst |=> !m_tvalid, "result present after reset")

  // an entry that matched nowhere carries score zero and no name choice
  `ASSERT_CLK(a_unmatched_zero, m_tvalid && !m_tdata[0] |-> m_tdata[13:1] == 13'd0,
              "unmatched entry with non-zero score or name flag")

endmodule

bind fuzzy_subsequence_scorer_top fss_checker u_fss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[sim/fuzzy_subsequence_scorer_checker.sv]
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] character, [8] no_character, [15:9] zero
  input  logic        s_tlast,
  input  logic        s_tuser,   // kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [0] entry_matched, [12:1] combined_score,
                                 // [13] name_was_best, [15:14] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          outstanding,
  output int          failures
);
  import fss_pkg::*;

  localparam int GAP_COST = 5;

  typedef struct packed {
    logic        hit;
    logic [11:0] score;
    logic        name_best;
  } entry_score_t;

  entry_score_t scores_due[$];

  // query registers as last written
  logic [63:0] query_lo;
  logic [63:0] query_hi;
  logic [4:0]  query_len;

  // running state of the string being scored
  int match_pos;
  int gap_total;
  int run_step;
  bit last_hit;
  bit word_start;
  int score_acc;
  int text_len;

  // outcome of the last closed name
  bit saved_name_hit;
  int saved_name_score;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    failures++;
  endtask

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic int active_len();
    return (query_len > MAX_QUERY) ? MAX_QUERY : int'(query_len);
  endfunction

  function automatic logic [7:0] query_byte(int i);
    return to_lower((i < 8) ? query_lo[i*8 +: 8] : query_hi[(i-8)*8 +: 8]);
  endfunction

  function automatic void restart_string();
    match_pos  = 0;
    gap_total  = 0;
    run_step   = 0;
    last_hit   = 0;
    word_start = 1;
    score_acc  = 0;
    text_len   = 0;
  endfunction

  function automatic void score_character(logic [7:0] c);
    if (match_pos < active_len()) begin
      if (to_lower(c) == query_byte(match_pos)) begin
        if (word_start) begin
          score_acc -= int'(WORD_START_BONUS);
        end
        if (last_hit) begin
          run_step = (run_step + 1) & 31;
          score_acc -= run_step;
        end else begin
          run_step = 0;
        end
        last_hit = 1;
        match_pos++;
      end else begin
        if (match_pos > 0 && gap_total < int'(GAP_LIMIT)) begin
          gap_total++;
        end
        last_hit = 0;
      end
    end
    word_start = (c == SPACE_CHAR);
    if (text_len < int'(MAX_STRING_LENGTH)) begin
      text_len++;
    end
  endfunction

  function automatic void take_item(logic [15:0] d, logic closes, logic kind);
    bit hit;
    int sc;
    int cat;
    int best;
    bit from_name;
    entry_score_t res;
    if (!d[8]) begin
      score_character(d[7:0]);
    end
    if (!closes) begin
      return;
    end
    if (active_len() == 0) begin
      hit = 1;
      sc  = 0;
    end else if (match_pos >= active_len()) begin
      hit = 1;
      sc  = score_acc + gap_total * GAP_COST + text_len;
    end else begin
      hit = 0;
      sc  = 0;
    end
    restart_string();
    if (!kind) begin
      saved_name_hit   = hit;
      saved_name_score = sc;
      return;
    end
    cat       = sc + int'(CATEGORY_PENALTY);
    best      = 0;
    from_name = 0;
    if (saved_name_hit && hit) begin
      from_name = (saved_name_score <= cat);
      best      = from_name ? saved_name_score : cat;
    end else if (saved_name_hit) begin
      from_name = 1;
      best      = saved_name_score;
    end else if (hit) begin
      best = cat;
    end
    if (best > int'(SCORE_LIMIT)) begin
      best = int'(SCORE_LIMIT);
    end
    res.hit       = saved_name_hit || hit;
    res.score     = best[11:0];
    res.name_best = from_name;
    scores_due.insert(scores_due.size(), res);
    saved_name_hit   = 0;
    saved_name_score = 0;
  endfunction

  task automatic check_score(logic [15:0] d);
    entry_score_t want;
    if (scores_due.size() == 0) begin
      report_mismatch("result item with none outstanding", int'(d), 0);
      return;
    end
    want = scores_due.pop_front();
    if (d[0] !== want.hit) begin
      report_mismatch("entry_matched", int'(d[0]), int'(want.hit));
    end
    if (d[12:1] !== want.score) begin
      report_mismatch("combined_score", int'($signed(d[12:1])), int'($signed(want.score)));
    end
    if (d[13] !== want.name_best) begin
      report_mismatch("name_was_best", int'(d[13]), int'(want.name_best));
    end
    if (d[15:14] !== 2'b00) begin
      report_mismatch("m_tdata padding", int'(d[15:14]), 0);
    end
  endtask

  initial begin
    query_lo         = '0;
    query_hi         = '0;
    query_len        = '0;
    saved_name_hit   = 0;
    saved_name_score = 0;
    restart_string();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        check_score(m_tdata);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY_LOW:  query_lo  = cfg_data;
          CFG_QUERY_HIGH: query_hi  = cfg_data;
          CFG_QUERY_LEN:  query_len = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        take_item(s_tdata, s_tlast, s_tuser);
      end
    end
    outstanding <= scores_due.size();
  end

endmodule

[sim/fuzzy_subsequence_scorer_top_test.sv]
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_top_test;
  import fss_pkg::*;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 40;      // counted items per random phase
  localparam int HOLD_CYCLES   = 300;     // long output stall
  localparam int DRAIN_CYCLES  = 6;       // extra wait once nothing is outstanding
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    bit          kind;
    logic [7:0]  ch;
    bit          none;
    bit          last;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;   // [7:0] character, [8] no_character, [15:9] zero
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0; // kind: 0 name, 1 category
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_QUERY_LOW;
  logic [63:0] cfg_data = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;        // [0] entry_matched, [12:1] combined_score,
                               // [13] name_was_best, [15:14] zero
  int          outstanding;
  int          failures;

  stream_item_t items_q[$];
  logic [7:0]   query_text[16];
  int           query_count;   // raw value for query_length, may exceed MAX_QUERY
  int           counted;
  bit           idle_on;
  bit           hold_req;
  int unsigned  cycles;

  fuzzy_subsequence_scorer_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fuzzy_subsequence_scorer_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .failures   (failures)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a result that never shows ends here
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL fuzzy_subsequence_scorer_top");
        $finish;
      end
    end
  end

  // result side: ready most of the time, random stall bursts while idling is on,
  // and one long hold-off on request so that a category end backs up the input
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] random_letter();
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
  endfunction

  // filler: plenty of spaces so word starts come often, mostly letters, some raw bytes
  function automatic logic [7:0] filler_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h20;
    if (r < 8) return random_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] query_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return random_letter();
    if (r < 7) return 8'h20;
    return 8'($urandom_range(0, 255));
  endfunction

  // flip the case of a letter now and then so case folding gets exercised
  function automatic logic [7:0] vary_case(logic [7:0] c);
    if ($urandom_range(0, 1)) begin
      if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
      if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    end
    return c;
  endfunction

  function automatic int active_count();
    return (query_count > MAX_QUERY) ? MAX_QUERY : query_count;
  endfunction

  task automatic queue_item(bit kind, logic [7:0] ch, bit none, bit last);
    stream_item_t it;
    it.kind = kind;
    it.ch   = ch;
    it.none = none;
    it.last = last;
    items_q.insert(items_q.size(), it);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // all three registers in back-to-back cycles; upper bits of the length
  // register are junk half the time since only the low five bits count
  task automatic load_query();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = query_text[i];
      hi[i*8 +: 8] = query_text[i+8];
    end
    len_word = $urandom_range(0, 1) ? {$urandom(), $urandom()} : 64'd0;
    len_word[4:0] = 5'(query_count);
    write_reg(CFG_QUERY_LOW, lo);
    write_reg(CFG_QUERY_HIGH, hi);
    write_reg(CFG_QUERY_LEN, len_word);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_query(int mode);
    for (int i = 0; i < 16; i++) begin
      query_text[i] = 8'($urandom_range(0, 255));
    end
    case (mode)
      1: begin                                // full length, all ones
        query_count = 16;
        for (int i = 0; i < 16; i++) query_text[i] = 8'hFF;
      end
      2: begin
        query_count   = 1;
        query_text[0] = query_char();
      end
      4: query_count = 0;                     // empty query: everything matches
      5: begin                                // length beyond the query store
        query_count = $urandom_range(17, 31);
        for (int i = 0; i < 16; i++) query_text[i] = query_char();
      end
      6: begin                                // full length, all zero bytes
        query_count = 16;
        for (int i = 0; i < 16; i++) query_text[i] = 8'h00;
      end
      default: begin
        query_count = $urandom_range(2, 6);
        for (int i = 0; i < query_count; i++) query_text[i] = query_char();
      end
    endcase
  endtask

  // one string; fit weaves the query in, stretch makes it long enough to
  // saturate the length counter and, with two or more query chars, the gaps
  task automatic add_string(bit kind, bit fit, bit stretch);
    logic [7:0] text[$];
    logic [7:0] gap_char;
    bit         close_apart;
    int         n;
    n = active_count();
    if (fit) begin
      for (int i = 0; i < n; i++) begin
        repeat ($urandom_range(0, 3)) text.insert(text.size(), filler_char());
        text.insert(text.size(), vary_case(query_text[i]));
        if (stretch && i == 0 && n >= 2) begin
          // never equal to the next query char, so every one is a gap
          gap_char = query_text[1];
          if (gap_char >= 8'h41 && gap_char <= 8'h5A) gap_char += 8'h20;
          gap_char ^= 8'h01;
          repeat (260) text.insert(text.size(), gap_char);
        end
      end
      repeat ($urandom_range(0, 2)) text.insert(text.size(), filler_char());
    end else begin
      repeat ($urandom_range(0, 8)) text.insert(text.size(), filler_char());
    end
    if (stretch && text.size() < 260) begin
      repeat (270) text.insert(text.size(), filler_char());
    end
    if (text.size() == 0) begin
      queue_item(kind, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
      counted++;
      return;
    end
    close_apart = ($urandom_range(0, 9) == 0);
    for (int j = 0; j < text.size(); j++) begin
      // stray empty items mid-string, ignored by the block
      if ($urandom_range(0, 15) == 0) begin
        queue_item($urandom_range(0, 1), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      if (j == text.size() - 1 && !close_apart) begin
        queue_item(kind, text[j], 1'b0, 1'b1);
      end else begin
        queue_item($urandom_range(0, 1), text[j], 1'b0, 1'b0);
      end
      counted++;
    end
    if (close_apart) begin
      queue_item(kind, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
      counted++;
    end
  endtask

  // mostly name then category; now and then a lone category, a lone name,
  // or a name closed twice before its category
  task automatic add_entry(bit stretch);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      add_string(1'b1, $urandom_range(0, 1), 1'b0);
    end else if (r == 1) begin
      add_string(1'b0, $urandom_range(0, 1), 1'b0);
    end else if (r == 2) begin
      add_string(1'b0, $urandom_range(0, 1), 1'b0);
      add_string(1'b0, $urandom_range(0, 1), 1'b0);
      add_string(1'b1, $urandom_range(0, 1), 1'b0);
    end else begin
      add_string(1'b0, $urandom_range(0, 2) != 0, stretch);
      add_string(1'b1, $urandom_range(0, 2) == 0, 1'b0);
    end
  endtask

  task automatic send_all();
    stream_item_t it;
    while (items_q.size() > 0) begin
      it = items_q.pop_front();
      if (idle_on && $urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= {7'd0, it.none, it.ch};
      s_tlast  <= it.last;
      s_tuser  <= it.kind;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
  endtask

  // outstanding is registered, so wait before trusting it; the extra
  // cycles cover a name end still in flight, which leaves nothing to wait on
  task automatic drain();
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit stretch;
    idle_on  = 1;
    hold_req = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: empty query, every string matches with zero
    queue_item(1'b0, "A", 1'b0, 1'b1);
    queue_item(1'b1, 8'h00, 1'b1, 1'b1);
    send_all();
    drain();

    for (int i = 0; i < 16; i++) query_text[i] = 8'h00;
    query_text[0] = "a";
    query_text[1] = "B";
    query_count   = 2;
    load_query();
    // name with word starts and a gap, category with a run
    queue_item(1'b0, "A", 1'b0, 1'b0);
    queue_item(1'b0, " ", 1'b0, 1'b0);
    queue_item(1'b0, "b", 1'b0, 1'b1);
    queue_item(1'b1, "a", 1'b0, 1'b0);
    queue_item(1'b1, "b", 1'b0, 1'b1);
    // category with no name before it
    queue_item(1'b1, "z", 1'b0, 1'b0);
    queue_item(1'b1, "z", 1'b0, 1'b0);
    queue_item(1'b1, "a", 1'b0, 1'b0);
    queue_item(1'b1, "b", 1'b0, 1'b1);
    // second name end replaces the first, then an empty category
    queue_item(1'b0, "q", 1'b0, 1'b1);
    queue_item(1'b0, "a", 1'b0, 1'b0);
    queue_item(1'b0, "b", 1'b0, 1'b1);
    queue_item(1'b1, 8'hFF, 1'b1, 1'b1);
    // neither string matches
    queue_item(1'b0, "b", 1'b0, 1'b1);
    queue_item(1'b1, "a", 1'b0, 1'b1);
    // empty item and kind 1 inside a name, zero byte as a gap
    queue_item(1'b1, 8'hFF, 1'b1, 1'b0);
    queue_item(1'b1, "a", 1'b0, 1'b0);
    queue_item(1'b1, 8'h00, 1'b0, 1'b0);
    queue_item(1'b0, "b", 1'b0, 1'b1);
    queue_item(1'b1, 8'h00, 1'b1, 1'b1);
    send_all();
    drain();

    // random phases, a fresh query each; last two run without any idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p < RANDOM_PHASES - 2);
      pick_query(p);
      load_query();
      hold_req = (p == 4);
      counted  = 0;
      stretch  = (p == 3);
      while (counted < PHASE_ITEMS) begin
        add_entry(stretch);
        stretch = 0;
      end
      send_all();
      drain();
    end

    if (failures == 0) begin
      $display("PASS fuzzy_subsequence_scorer_top");
    end else begin
      $display("FAIL fuzzy_subsequence_scorer_top");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/fss_pkg.sv
src/fss_char_match.sv
src/fss_combine.sv
src/fuzzy_subsequence_scorer_top.sv
src/fss_checker.sv
sim/fuzzy_subsequence_scorer_checker.sv
sim/fuzzy_subsequence_scorer_top_test.sv
